// File: rtl/core/young_tableau_max_queue_core_macros.svh
// assertion helpers for the young tableau queue core
`ifndef YOUNG_TABLEAU_MAX_QUEUE_CORE_MACROS_SVH
`define YOUNG_TABLEAU_MAX_QUEUE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define YTMQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define YTMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ytmq_pkg.sv
`default_nettype none

package ytmq_pkg;

    localparam int ROWS   = 8;
    localparam int COLS   = 8;
    localparam int DEPTH  = ROWS * COLS;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;

    localparam logic signed [DATA_W-1:0] EMPTY_MARK = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic publish;
    } ytmq_cmd_t;

    typedef struct packed {
        logic refuse;
        logic stop;
    } ytmq_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/ytmq_req_if.sv
`default_nettype none

interface ytmq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic signed [ytmq_pkg::DATA_W-1:0]  value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ytmq_rsp_if.sv
`default_nettype none

interface ytmq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [ytmq_pkg::DATA_W-1:0]  max_value;
    logic        [1:0]                   status;

    modport source (output valid, output max_value, output status, input ready);
    modport sink   (input valid, input max_value, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ytmq_ctrl.sv
`default_nettype none

module ytmq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ytmq_pkg::ytmq_cmd_t    cmd,
    input  ytmq_pkg::ytmq_stat_t   stat
);
    import ytmq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SIFT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                // start cell is in the read register now
                cmd.start  = 1'b1;
                state_next = stat.refuse ? S_DONE : S_SIFT;
            end
            S_SIFT:
            begin
                cmd.step = 1'b1;
                if (stat.stop)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/core/ytmq_dpath.sv
`default_nettype none

module ytmq_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ytmq_pkg::ytmq_cmd_t                 cmd,
    output ytmq_pkg::ytmq_stat_t                stat,
    input  logic                                in_func,
    input  logic signed [ytmq_pkg::DATA_W-1:0]  in_value,
    output logic signed [ytmq_pkg::DATA_W-1:0]  max_value,
    output logic        [1:0]                   status
);
    import ytmq_pkg::*;

    // cell store, valid bits stand in for the all-empty reset
    logic signed [DATA_W-1:0] cell_mem [DEPTH];
    logic        [DEPTH-1:0]  cell_vld_reg;

    logic signed [DATA_W-1:0] rda_data_reg;
    logic signed [DATA_W-1:0] rdb_data_reg;
    logic                     rda_vld_reg;
    logic                     rdb_vld_reg;

    logic                     func_reg;
    logic                     func_next;
    logic signed [DATA_W-1:0] x_reg;
    logic        [ROW_W-1:0]  row_reg;
    logic        [ROW_W-1:0]  row_next;
    logic        [COL_W-1:0]  col_reg;
    logic        [COL_W-1:0]  col_next;
    logic        [IDX_W-1:0]  idx_reg;
    logic        [IDX_W-1:0]  idx_next;

    logic signed [DATA_W-1:0] res_value_reg;
    logic        [1:0]        res_status_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic        [1:0]        out_status_reg;

    logic signed [DATA_W-1:0] a_val;
    logic signed [DATA_W-1:0] b_val;
    logic signed [DATA_W-1:0] wdata;
    logic                     a_in;
    logic                     b_in;
    logic                     a_ok;
    logic                     b_ok;
    logic                     take_a;
    logic                     stop;
    logic                     refuse;
    logic        [IDX_W-1:0]  rd_a_addr;
    logic        [IDX_W-1:0]  rd_b_addr;

    assign a_val = rda_vld_reg ? rda_data_reg : EMPTY_MARK;
    assign b_val = rdb_vld_reg ? rdb_data_reg : EMPTY_MARK;

    // one sift step: port a is the up/down neighbor, port b the left/right one
    always_comb
    begin
        if (func_reg == FUNC_INSERT)
        begin
            a_in   = (row_reg != '0);
            b_in   = (col_reg != '0);
            a_ok   = a_in && (a_val < x_reg);
            b_ok   = b_in && (b_val < x_reg);
            take_a = a_ok && (!b_ok || (a_val <= b_val));
            refuse = (a_val != EMPTY_MARK);
        end
        else
        begin
            // x holds the empty marker as the hole
            a_in   = (row_reg != ROW_W'(ROWS - 1));
            b_in   = (col_reg != COL_W'(COLS - 1));
            a_ok   = a_in && (a_val > x_reg);
            b_ok   = b_in && (b_val > x_reg);
            take_a = a_ok && (!b_ok || (a_val >= b_val));
            refuse = (a_val == EMPTY_MARK);
        end
        stop  = !a_ok && !b_ok;
        wdata = stop ? x_reg : (take_a ? a_val : b_val);
    end

    always_comb
    begin
        func_next = func_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        idx_next  = idx_reg;
        if (cmd.load)
        begin
            func_next = in_func;
            if (in_func == FUNC_INSERT)
            begin
                row_next = ROW_W'(ROWS - 1);
                col_next = COL_W'(COLS - 1);
                idx_next = IDX_W'(DEPTH - 1);
            end
            else
            begin
                row_next = '0;
                col_next = '0;
                idx_next = '0;
            end
        end
        else if (cmd.step && !stop)
        begin
            if (func_reg == FUNC_INSERT)
            begin
                if (take_a)
                begin
                    row_next = row_reg - ROW_W'(1);
                    idx_next = idx_reg - IDX_W'(COLS);
                end
                else
                begin
                    col_next = col_reg - COL_W'(1);
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            else
            begin
                if (take_a)
                begin
                    row_next = row_reg + ROW_W'(1);
                    idx_next = idx_reg + IDX_W'(COLS);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // load reads the start cell, otherwise the neighbors of the next position
    always_comb
    begin
        if (cmd.load)
        begin
            rd_a_addr = idx_next;
            rd_b_addr = idx_next;
        end
        else if (func_next == FUNC_INSERT)
        begin
            rd_a_addr = (row_next != '0) ? idx_next - IDX_W'(COLS) : '0;
            rd_b_addr = (col_next != '0) ? idx_next - IDX_W'(1) : '0;
        end
        else
        begin
            rd_a_addr = (row_next != ROW_W'(ROWS - 1)) ? idx_next + IDX_W'(COLS) : '0;
            rd_b_addr = (col_next != COL_W'(COLS - 1)) ? idx_next + IDX_W'(1) : '0;
        end
    end

    // the written cell is never one of the neighbors read in the same cycle
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            cell_mem[idx_reg] <= wdata;
        end
        rda_data_reg <= cell_mem[rd_a_addr];
        rdb_data_reg <= cell_mem[rd_b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_vld_reg <= '0;
            rda_vld_reg  <= 1'b0;
            rdb_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.step)
            begin
                cell_vld_reg[idx_reg] <= 1'b1;
            end
            rda_vld_reg <= cell_vld_reg[rd_a_addr];
            rdb_vld_reg <= cell_vld_reg[rd_b_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        idx_reg  <= idx_next;
        if (cmd.load)
        begin
            x_reg <= (in_func == FUNC_INSERT) ? in_value : EMPTY_MARK;
        end
        if (cmd.start)
        begin
            res_value_reg <= (func_reg == FUNC_INSERT) ? '0 : a_val;
            if (!refuse)
            begin
                res_status_reg <= STATUS_DONE;
            end
            else if (func_reg == FUNC_INSERT)
            begin
                res_status_reg <= STATUS_FULL;
            end
            else
            begin
                res_status_reg <= STATUS_EMPTY;
            end
        end
        if (cmd.publish)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign stat.refuse = refuse;
    assign stat.stop   = stop;
    assign max_value   = out_value_reg;
    assign status      = out_status_reg;

endmodule

`default_nettype wire

// File: rtl/core/young_tableau_max_queue_core.sv
// Max priority queue kept as an 8 by 8 Young tableau of signed 32-bit cells in
// a two-read, one-write cell memory; the most negative value marks an empty
// cell and all cells read as empty right after reset, with no clearing pass.
// A request on req is an insert (func 0) or a remove-max (func 1); every
// request yields one beat on rsp with max_value and status (0 done, 1 insert
// refused because full, 2 remove on empty). A request is taken only in idle,
// so each one passes through load, start, sift and done before the next is
// accepted; the sift moves k cells (0 to ROWS + COLS - 2), and a refused
// request skips the sift. The sift advances one cell per cycle: each cycle
// compares the two neighbors read from the cell memory, writes the winner
// back and reads the next pair. A finished result waits in the output
// register while the next request is taken.
`default_nettype none

module young_tableau_max_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    ytmq_req_if.sink    req,
    ytmq_rsp_if.source  rsp
);
    import ytmq_pkg::*;

    ytmq_cmd_t  cmd;
    ytmq_stat_t stat;

    ytmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ytmq_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_func   (req.func),
        .in_value  (req.value),
        .max_value (rsp.max_value),
        .status    (rsp.status)
    );

`include "young_tableau_max_queue_core_macros.svh"

    `YTMQ_ASSERT_NOW(a_cmd_onehot, clk, rst_n, 1'b1,
        $onehot0({cmd.load, cmd.start, cmd.step, cmd.publish}),
        "more than one datapath command at once")
    `YTMQ_ASSERT_NOW(a_load_on_accept, clk, rst_n, 1'b1,
        cmd.load == (req.valid && req.ready),
        "load command does not match request accept")
    `YTMQ_ASSERT_NEXT(a_refuse_no_sift, clk, rst_n, cmd.start && stat.refuse,
        !cmd.step && !cmd.load,
        "refused request went on to sift")
    `YTMQ_ASSERT_NEXT(a_publish_valid, clk, rst_n, cmd.publish,
        rsp.valid,
        "published result not presented on rsp")

endmodule

`default_nettype wire
